// ===== rtl/tpv_pkg.sv =====
// ----------------------------------------------------------------------------
// tpv_pkg
// Shared types, constants and register indexes of the ternary pattern vote
// block.
// ----------------------------------------------------------------------------
package tpv_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int WIN           = 9;
	localparam int LINES         = 8;
	localparam int PIX_W         = 8;
	localparam int LINE_DATA_W   = LINES * PIX_W;
	localparam int NUM_DIR       = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [7:0]  RST_THRESHOLD    = 8'd2;
	localparam logic [10:0] RST_LINE_WIDTH   = 11'd768;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd576;

	// Direction codes.
	localparam logic [1:0] CODE_DARKER   = 2'd0;
	localparam logic [1:0] CODE_SIMILAR  = 2'd1;
	localparam logic [1:0] CODE_BRIGHTER = 2'd2;

	// Neighbor offsets, clockwise from the upper-left.
	localparam int DIR_DR [NUM_DIR] = '{-1, -1, -1, 0, 1, 1, 1, 0};
	localparam int DIR_DC [NUM_DIR] = '{-1, 0, 1, 1, 1, 0, -1, -1};
	localparam int GRID_POS [3]     = '{1, 4, 7};

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [WIN-1:0][PIX_W-1:0] colv_t;
	typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;
	typedef logic [NUM_DIR-1:0][1:0] codes_t;
	typedef logic [LINE_DATA_W-1:0] line_word_t;

	typedef struct packed {
		logic busy;
	} ls_status_t;

endpackage

// ===== rtl/tpv_intf.sv =====
// ----------------------------------------------------------------------------
// tpv channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tpv_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       start_of_frame;

	modport source (output valid, output pixel, output start_of_frame, input ready);
	modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface tpv_result_if;
	logic       valid;
	logic       ready;
	logic       window_valid;
	logic [9:0] center_x;
	logic [9:0] center_y;
	logic [1:0] code_nw;
	logic [1:0] code_n;
	logic [1:0] code_ne;
	logic [1:0] code_e;
	logic [1:0] code_se;
	logic [1:0] code_s;
	logic [1:0] code_sw;
	logic [1:0] code_w;

	modport source (output valid, output window_valid, output center_x, output center_y,
		output code_nw, output code_n, output code_ne, output code_e,
		output code_se, output code_s, output code_sw, output code_w, input ready);
	modport sink   (input valid, input window_valid, input center_x, input center_y,
		input code_nw, input code_n, input code_ne, input code_e,
		input code_se, input code_s, input code_sw, input code_w, output ready);
endinterface

interface tpv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tpv_line_store.sv =====
// ----------------------------------------------------------------------------
// tpv_line_store
// Eight-line pixel store, one word per column holding all eight lines. Swept
// to zero after reset; a read of the column written in the same cycle is
// forwarded.
// ----------------------------------------------------------------------------
module tpv_line_store #(
	parameter int MAX_WIDTH = tpv_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output tpv_pkg::line_word_t          rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  tpv_pkg::line_word_t          wr_data,
	output tpv_pkg::ls_status_t          status
);
	import tpv_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	line_word_t mem [MAX_WIDTH];
	line_word_t rd_q;
	line_word_t fwd_data_q;
	logic       fwd_sel_q;
	logic       busy_q;
	logic [AW-1:0] clr_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	line_word_t    mem_wdata;

	always_comb begin
		if (busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_en;
			mem_waddr = wr_addr;
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_q     <= '0;
			fwd_sel_q <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(MAX_WIDTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (rd_en) begin
				fwd_sel_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data     = fwd_sel_q ? fwd_data_q : rd_q;
	assign status.busy = busy_q;

endmodule

// ===== rtl/tpv_window.sv =====
// ----------------------------------------------------------------------------
// tpv_window
// 9x9 pixel window; each accepted column enters on the right.
// ----------------------------------------------------------------------------
module tpv_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  tpv_pkg::colv_t col_vec,
	output tpv_pkg::win_t  win
);
	import tpv_pkg::*;

	win_t win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			for (int r = 0; r < WIN; r++) begin
				for (int c = 0; c < WIN - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][WIN-1] <= col_vec[r];
			end
		end
	end

	assign win = win_q;

endmodule

// ===== rtl/tpv_vote.sv =====
// ----------------------------------------------------------------------------
// tpv_vote
// Ternary comparison of the nine sample points against their neighbors and
// the per-direction majority vote.
// ----------------------------------------------------------------------------
module tpv_vote (
	input  logic [7:0]      threshold,
	input  tpv_pkg::win_t   win,
	output tpv_pkg::codes_t codes
);
	import tpv_pkg::*;

	logic [NUM_DIR-1:0][8:0] bright_v;
	logic [NUM_DIR-1:0][8:0] dark_v;
	logic [NUM_DIR-1:0][8:0] similar_v;
	logic [NUM_DIR-1:0][3:0] n_bright;
	logic [NUM_DIR-1:0][3:0] n_dark;
	logic [NUM_DIR-1:0][3:0] n_similar;

	always_comb begin
		logic [8:0] u;
		logic [8:0] nb;
		logic [8:0] t;
		t = {1'b0, threshold};
		for (int d = 0; d < NUM_DIR; d++) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					u  = {1'b0, win[GRID_POS[a]][GRID_POS[b]]};
					nb = {1'b0, win[GRID_POS[a] + DIR_DR[d]][GRID_POS[b] + DIR_DC[d]]};
					// u <= nb - t and u >= nb + t, kept free of negative values.
					bright_v[d][a*3+b]  = (u + t) <= nb;
					dark_v[d][a*3+b]    = !bright_v[d][a*3+b] && (u >= nb + t);
					similar_v[d][a*3+b] = !bright_v[d][a*3+b] && !dark_v[d][a*3+b];
				end
			end
			n_bright[d]  = 4'($countones(bright_v[d]));
			n_dark[d]    = 4'($countones(dark_v[d]));
			n_similar[d] = 4'($countones(similar_v[d]));
			priority if (n_bright[d] >= n_similar[d] && n_bright[d] >= n_dark[d]) begin
				codes[d] = CODE_BRIGHTER;
			end else if (n_similar[d] > n_bright[d] && n_similar[d] > n_dark[d]) begin
				codes[d] = CODE_SIMILAR;
			end else begin
				codes[d] = CODE_DARKER;
			end
		end
	end

endmodule

// ===== rtl/ternary_pattern_vote_core.sv =====
// ----------------------------------------------------------------------------
// ternary_pattern_vote_core
// Streaming local ternary pattern vote over a 9x9 pixel window.
// ----------------------------------------------------------------------------
// Pixels enter on the pix channel in raster order, one per transaction;
// start_of_frame puts the pixel at column 0, row 0. Every pixel yields one
// transaction on the res channel, carrying the eight direction codes of the
// window whose center lies four rows up and four columns left of it, or
// window_valid low with all other fields zero near the frame border.
// The cfg channel writes threshold (index 0), line_width (1) and
// frame_height (2); it is always ready. It must be written while the block
// idles; the block itself does not enforce this. Throughput is one pixel
// per cycle unless the receiver stalls or the line store is being cleared.
// After a pixel transaction the line store read is registered, then the
// window shifts, then the vote loads into the result register. The line
// store is one word of eight lines per column, read and written once per
// pixel through a single memory. After reset the line store is cleared,
// one column per cycle, while pix.ready stays low; the configuration
// registers return to threshold 2, width 768, height 576.
// When the receiver stalls, the result register holds and the stages behind
// it fill; pix.ready drops once stage 1, holding the store read, cannot advance.
// ----------------------------------------------------------------------------
module ternary_pattern_vote_core #(
	parameter int MAX_WIDTH = tpv_pkg::DEF_MAX_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	tpv_pixel_if.sink  pix,
	tpv_result_if.source res,
	tpv_cfg_if.sink    cfg
);
	import tpv_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = AW + 1;

	// Configuration registers.
	logic [7:0]  thr_q;
	logic [10:0] lw_q;
	logic [10:0] fh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_THRESHOLD;
			lw_q  <= RST_LINE_WIDTH;
			fh_q  <= RST_FRAME_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_THRESHOLD:    thr_q <= cfg.data[7:0];
				REG_LINE_WIDTH:   lw_q  <= cfg.data;
				REG_FRAME_HEIGHT: fh_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] w_eff;
	logic [10:0]   h_eff;

	always_comb begin
		if (32'(lw_q) < 32'(WIN)) begin
			w_eff = WW'(WIN);
		end else if (32'(lw_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(lw_q);
		end
		if (fh_q < 11'(WIN)) begin
			h_eff = 11'(WIN);
		end else if (fh_q > 11'(MAX_HEIGHT)) begin
			h_eff = 11'(MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
	end

	// Pipeline control.
	logic v_s1, v_s2, res_v_q;
	logic out_load, s2_free, s1_adv, s1_free, acc;
	ls_status_t ls_status;

	assign out_load  = v_s2 && (!res_v_q || res.ready);
	assign s2_free   = !v_s2 || out_load;
	assign s1_adv    = v_s1 && s2_free;
	assign s1_free   = !v_s1 || s1_adv;
	assign pix.ready = s1_free && !ls_status.busy;
	assign acc       = pix.valid && pix.ready;

	// Position of the incoming pixel.
	logic [AW-1:0] col_q;
	logic [9:0]    row_q;
	logic [AW-1:0] col_cur;
	logic [9:0]    row_cur;
	logic [WW-1:0] col_inc;
	logic [10:0]   row_inc;

	always_comb begin
		col_cur = pix.start_of_frame ? '0 : col_q;
		row_cur = pix.start_of_frame ? '0 : row_q;
		if ({1'b0, col_cur} >= w_eff) begin
			col_cur = '0;
		end
		if ({1'b0, row_cur} >= h_eff) begin
			row_cur = '0;
		end
		col_inc = {1'b0, col_cur} + 1'b1;
		row_inc = {1'b0, row_cur} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[9:0];
			end else begin
				col_q <= col_inc[AW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Stage 1: line store read in flight.
	pix_t          px_s1;
	logic [AW-1:0] col_s1;
	logic [9:0]    row_s1;
	line_word_t    ls_rd;
	line_word_t    ls_wr;
	colv_t         col_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1  <= pix.pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
		end
	end

	tpv_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (col_cur),
		.rd_data (ls_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (ls_wr),
		.status  (ls_status)
	);

	// Oldest line sits at the top of the column, the new pixel at the bottom.
	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			col_vec[k] = ls_rd[(LINES-1-k)*PIX_W +: PIX_W];
		end
		col_vec[LINES] = px_s1;
	end

	assign ls_wr = {ls_rd[LINE_DATA_W-PIX_W-1:0], px_s1};

	// Stage 2: window updated, position registered.
	win_t       win;
	logic       wv_s2;
	logic [9:0] cx_s2;
	logic [9:0] cy_s2;
	logic       wv_s1;

	assign wv_s1 = (32'(col_s1) >= 32'(WIN - 1)) && (row_s1 >= 10'(WIN - 1));

	tpv_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_adv),
		.col_vec  (col_vec),
		.win      (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			wv_s2 <= wv_s1;
			cx_s2 <= wv_s1 ? 10'(32'(col_s1) - 32'd4) : '0;
			cy_s2 <= wv_s1 ? (row_s1 - 10'd4) : '0;
		end
	end

	// Vote and result register.
	codes_t codes;
	codes_t codes_q;
	logic   wv_q;
	logic [9:0] cx_q;
	logic [9:0] cy_q;

	tpv_vote u_vote (
		.threshold (thr_q),
		.win       (win),
		.codes     (codes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (!res_v_q || res.ready) begin
			res_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			wv_q    <= wv_s2;
			cx_q    <= cx_s2;
			cy_q    <= cy_s2;
			codes_q <= wv_s2 ? codes : '0;
		end
	end

	assign res.valid        = res_v_q;
	assign res.window_valid = wv_q;
	assign res.center_x     = cx_q;
	assign res.center_y     = cy_q;
	assign res.code_nw      = codes_q[0];
	assign res.code_n       = codes_q[1];
	assign res.code_ne      = codes_q[2];
	assign res.code_e       = codes_q[3];
	assign res.code_se      = codes_q[4];
	assign res.code_s       = codes_q[5];
	assign res.code_sw      = codes_q[6];
	assign res.code_w       = codes_q[7];

	// No pixel enters while the line store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ls_status.busy |-> !pix.ready)
		else $error("pixel channel ready during line store clear");

	// A result outside the frame carries no position and no codes.
	a_invalid_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.window_valid |-> res.center_x == 10'd0 && res.center_y == 10'd0
			&& codes_q == '0)
		else $error("border result has nonzero fields");

	// A valid window center lies at least four pixels inside the frame.
	a_center_inside: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.window_valid |-> res.center_x >= 10'd4 && res.center_y >= 10'd4)
		else $error("window center too close to the frame edge");

	// Once the last result is taken with nothing behind it, the output empties.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !v_s2 |=> !res.valid)
		else $error("result repeated after transaction");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Ternary pattern vote core testbench
// Streams gray pixels through the core under several line, frame and
// threshold settings and compares every result transaction, field by field,
// against a behavioral model of the line stores, the 9x9 window and the
// per-direction vote.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpv_pkg::*;

	localparam int LINE_MAX    = DEF_MAX_WIDTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;

	typedef struct {
		logic [7:0] value;
		logic       sof;
		logic       drain;
	} pixel_item_t;

	typedef struct packed {
		logic       window_valid;
		logic [9:0] center_x;
		logic [9:0] center_y;
		codes_t     codes;
	} vote_t;

	logic clk;
	logic arst_n;

	tpv_pixel_if  pix ();
	tpv_result_if res ();
	tpv_cfg_if    cfg ();

	ternary_pattern_vote_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	pixel_item_t pixel_feed[$];
	vote_t       expected_votes[$];
	int          pixels_queued = 0;
	int          pixels_taken  = 0;
	int          error_count   = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 19;
	int          recv_idle_pct = 60;

	string dir_name [NUM_DIR] = '{"code_nw", "code_n", "code_ne", "code_e",
		"code_se", "code_s", "code_sw", "code_w"};

	// Model copy of the block state and its registers.
	logic [7:0]  line_mem [LINES][LINE_MAX];
	logic [7:0]  win_pix [WIN][WIN];
	int unsigned col_pos;
	int unsigned row_pos;
	logic [7:0]  thr_reg;
	logic [10:0] width_reg;
	logic [10:0] height_reg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(string msg);
		error_count++;
		$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic logic [1:0] vote_direction(int d);
		int brighter = 0;
		int similar  = 0;
		int darker   = 0;
		int u;
		int nb;
		int r;
		int c;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				r  = GRID_POS[a];
				c  = GRID_POS[b];
				u  = win_pix[r][c];
				nb = win_pix[r + DIR_DR[d]][c + DIR_DC[d]];
				if (u <= nb - int'(thr_reg))
					brighter++;
				else if (u >= nb + int'(thr_reg))
					darker++;
				else
					similar++;
			end
		end
		if (brighter >= similar && brighter >= darker)
			return CODE_BRIGHTER;
		if (similar > brighter && similar > darker)
			return CODE_SIMILAR;
		return CODE_DARKER;
	endfunction

	// Advances the model by one pixel and returns the vote it produces.
	function automatic vote_t predict_vote(logic [7:0] value, logic sof);
		vote_t       v;
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		logic [7:0]  column [WIN];
		w = (width_reg < WIN) ? WIN : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
		h = (height_reg < WIN) ? WIN : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		col = col_pos;
		row = row_pos;

		// Oldest line on top, the new pixel at the bottom of the column.
		for (int k = 0; k < LINES; k++)
			column[k] = line_mem[LINES - 1 - k][col];
		column[LINES] = value;
		for (int k = LINES - 1; k > 0; k--)
			line_mem[k][col] = line_mem[k - 1][col];
		line_mem[0][col] = value;

		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN - 1; c++)
				win_pix[r][c] = win_pix[r][c + 1];
			win_pix[r][WIN - 1] = column[r];
		end

		v = '0;
		if (col >= WIN - 1 && row >= WIN - 1) begin
			v.window_valid = 1'b1;
			v.center_x     = 10'(col - 4);
			v.center_y     = 10'(row - 4);
			for (int d = 0; d < NUM_DIR; d++)
				v.codes[d] = vote_direction(d);
		end

		col_pos = col + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = row + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
		return v;
	endfunction

	function automatic void push_pixel(logic [7:0] value, logic sof, logic drain);
		pixel_item_t item;
		item.value = value;
		item.sof   = sof;
		item.drain = drain;
		pixel_feed.push_back(item);
		pixels_queued++;
	endfunction

	// Picture content: full noise, flat areas with small noise, black and white,
	// or flat areas with scattered outliers.
	function automatic logic [7:0] scene_pixel(int mode, int base);
		int p;
		case (mode)
			0: p = $urandom_range(255);
			1: p = base + int'($urandom_range(6)) - 3;
			2: p = $urandom_range(1) ? 255 : 0;
			default: begin
				if ($urandom_range(3) == 0)
					p = $urandom_range(255);
				else
					p = base + int'($urandom_range(4)) - 2;
			end
		endcase
		if (p < 0)
			p = 0;
		if (p > 255)
			p = 255;
		return 8'(p);
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixels_taken != pixels_queued || expected_votes.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_THRESHOLD:    thr_reg    = value[7:0];
			REG_LINE_WIDTH:   width_reg  = value;
			REG_FRAME_HEIGHT: height_reg = value;
			default: ;
		endcase
	endtask

	task automatic run_phase(logic [7:0] thr, logic [10:0] width, logic [10:0] height,
			int count, int mode, bit restart);
		int base;
		int drain_at;
		wait_idle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_LINE_WIDTH, width);
		write_reg(REG_FRAME_HEIGHT, height);
		base     = $urandom_range(255);
		drain_at = $urandom_range(count - 1);
		for (int i = 0; i < count; i++)
			push_pixel(scene_pixel(mode, base), (restart && i == 0) || $urandom_range(199) == 0,
				i == drain_at);
	endtask

	// Pixel driver. An item flagged for draining is held back until every
	// result already owed by the core has come out.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix.valid          <= 1'b0;
			pix.pixel          <= '0;
			pix.start_of_frame <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				expected_votes.push_back(predict_vote(pix.pixel, pix.start_of_frame));
				pixels_taken++;
			end
			if (!pix.valid || pix.ready) begin
				if (pixel_feed.size() > 0 && !(pixel_feed[0].drain && expected_votes.size() > 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					pix.valid          <= 1'b1;
					pix.pixel          <= pixel_feed[0].value;
					pix.start_of_frame <= pixel_feed[0].sof;
					pixel_feed.pop_front();
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin : result_monitor
		vote_t got;
		vote_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got.window_valid = res.window_valid;
				got.center_x     = res.center_x;
				got.center_y     = res.center_y;
				got.codes        = {res.code_w, res.code_sw, res.code_s, res.code_se,
					res.code_e, res.code_ne, res.code_n, res.code_nw};
				if (expected_votes.size() == 0) begin
					report_error("result transaction with no pixel outstanding");
				end else begin
					want = expected_votes.pop_front();
					if (got.window_valid !== want.window_valid)
						report_error($sformatf("window_valid got %0d expected %0d",
							got.window_valid, want.window_valid));
					if (got.center_x !== want.center_x)
						report_error($sformatf("center_x got %0d expected %0d",
							got.center_x, want.center_x));
					if (got.center_y !== want.center_y)
						report_error($sformatf("center_y got %0d expected %0d",
							got.center_y, want.center_y));
					for (int d = 0; d < NUM_DIR; d++)
						if (got.codes[d] !== want.codes[d])
							report_error($sformatf("%s got %0d expected %0d (center %0d,%0d)",
								dir_name[d], got.codes[d], want.codes[d],
								want.center_x, want.center_y));
				end
			end
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int random_pixels;
		int count;
		logic [7:0]  thr;
		logic [10:0] width;
		logic [10:0] height;

		arst_n             = 1'b0;
		pix.valid          = 1'b0;
		pix.pixel          = '0;
		pix.start_of_frame = 1'b0;
		res.ready          = 1'b0;
		cfg.valid          = 1'b0;
		cfg.index          = REG_THRESHOLD;
		cfg.data           = '0;
		thr_reg            = RST_THRESHOLD;
		width_reg          = RST_LINE_WIDTH;
		height_reg         = RST_FRAME_HEIGHT;
		col_pos            = 0;
		row_pos            = 0;
		foreach (line_mem[i, j])
			line_mem[i][j] = '0;
		foreach (win_pix[i, j])
			win_pix[i][j] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The line store is cleared after reset before the first pixel is taken.
		do
			@(posedge clk);
		while (!pix.ready);

		// Reset settings, pixel extremes and a frame restart in mid-line. The
		// lines are long, so every window here is incomplete.
		push_pixel(8'h00, 1'b1, 1'b0);
		push_pixel(8'hFF, 1'b0, 1'b0);
		for (int i = 0; i < 10; i++)
			push_pixel(8'($urandom_range(255)), 1'b0, 1'b0);
		push_pixel(8'hFF, 1'b1, 1'b0);
		for (int i = 0; i < 12; i++)
			push_pixel(8'($urandom_range(255)), 1'b0, 1'b0);

		// The column now lies past the new line width: the counters must wrap
		// without a frame start.
		run_phase(8'd0, 11'd9, 11'd9, 120, 1, 1'b0);
		run_phase(8'd255, 11'd10, 11'd12, 100, 2, 1'b1);

		send_idle_pct = 60;
		recv_idle_pct = 19;
		// Out-of-range sizes are clamped to the nearest legal value.
		run_phase(8'($urandom_range(4)), 11'd0, 11'd2047, 90, 3, 1'b1);
		run_phase(8'd40, 11'd2047, 11'd0, 20, 0, 1'b1);

		random_pixels = 0;
		while (random_pixels < 90) begin
			if (random_pixels >= 45) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			count  = $urandom_range(100, 50);
			thr    = $urandom_range(1) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
			width  = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
				: 11'($urandom_range(20, 9));
			height = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
				: 11'($urandom_range(16, 9));
			run_phase(thr, width, height, count, int'($urandom_range(3)),
				1'($urandom_range(1)));
			random_pixels += count;
		end

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
